FILE: sv/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared width constants, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOUND,
      ST_DIV,
      ST_TEST,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic next_div;
      logic verdict_we;
      logic verdict;
      logic result_we;
   } cmd_type;

   typedef struct packed {
      logic below_two;
      logic over_bound;
      logic div_last;
      logic rem_zero;
   } status_type;

endpackage

FILE: sv/tdpt_datapath.sv
// ----------------------------------------------------------------------------
// tdpt_datapath
// Holds the value under test, the trial divisor and its square, a one bit a
// cycle restoring remainder unit, the verdict and the result register.
// ----------------------------------------------------------------------------
module tdpt_datapath (
   input  logic                                   clock,
   input  logic signed [tdpt_pkg::VALUE_WIDTH-1:0] req_value,
   input  tdpt_pkg::cmd_type                       cmd,
   output tdpt_pkg::status_type                    status,
   output logic                                   rsp_is_prime
);
   import tdpt_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [VALUE_WIDTH:0]   sq_ff, sq_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   verdict_ff, verdict_in;
   logic                   result_ff, result_in;
   logic [VALUE_WIDTH:0]   shifted;
   logic [VALUE_WIDTH:0]   diff;

   assign shifted = {rem_ff, value_ff[cnt_ff]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      value_in   = value_ff;
      div_in     = div_ff;
      sq_in      = sq_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      verdict_in = verdict_ff;
      result_in  = result_ff;
      if (cmd.load) begin
         value_in = VALUE_WIDTH'(req_value);
         div_in   = VALUE_WIDTH'(2);
         sq_in    = (VALUE_WIDTH+1)'(4);
      end
      if (cmd.next_div) begin
         div_in = div_ff + VALUE_WIDTH'(1);
         sq_in  = sq_ff + {div_ff, 1'b1};
      end
      if (cmd.div_start) begin
         rem_in = '0;
         cnt_in = CNT_WIDTH'(VALUE_WIDTH - 1);
      end
      if (cmd.div_step) begin
         rem_in = diff[VALUE_WIDTH] ? shifted[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
         cnt_in = cnt_ff - CNT_WIDTH'(1);
      end
      if (cmd.verdict_we) begin
         verdict_in = cmd.verdict;
      end
      if (cmd.result_we) begin
         result_in = verdict_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      div_ff     <= div_in;
      sq_ff      <= sq_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      verdict_ff <= verdict_in;
      result_ff  <= result_in;
   end

   assign status.below_two  = value_ff[VALUE_WIDTH-1] || (value_ff[VALUE_WIDTH-1:1] == '0);
   assign status.over_bound = sq_ff > {1'b0, value_ff};
   assign status.div_last   = (cnt_ff == '0);
   assign status.rem_zero   = (rem_ff == '0);
   assign rsp_is_prime      = result_ff;

endmodule

FILE: sv/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequences one item: bound check, remainder, zero test, next divisor, and
// hands the verdict to the result register when it is free.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tdpt_pkg::status_type status,
   output tdpt_pkg::cmd_type    cmd
);
   import tdpt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_BOUND;
         end
         ST_BOUND: begin
            if (status.below_two || status.over_bound) state_in = ST_REPORT;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_TEST;
         end
         ST_TEST: begin
            if (status.rem_zero) state_in = ST_REPORT;
            else state_in = ST_BOUND;
         end
         ST_REPORT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_BOUND: begin
            if (status.below_two) begin
               cmd.verdict_we = 1'b1;
               cmd.verdict    = 1'b0;
            end else if (status.over_bound) begin
               cmd.verdict_we = 1'b1;
               cmd.verdict    = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_TEST: begin
            if (status.rem_zero) begin
               cmd.verdict_we = 1'b1;
               cmd.verdict    = 1'b0;
            end else begin
               cmd.next_div = 1'b1;
            end
         end
         ST_REPORT: begin
            cmd.result_we = slot_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.result_we) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test of a signed integer by trial division.
// ----------------------------------------------------------------------------
// One item at a time: values below two raise rsp_valid with not prime.
// Otherwise each trial divisor d = 2, 3, ... takes a bound check against d*d,
// a one bit a cycle restoring remainder and a zero test. A finished result
// waits in an output register, and the next item is accepted while it waits.
module trial_division_prime_test (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [tdpt_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_is_prime
);
   import tdpt_pkg::*;

   cmd_type    cmd;
   status_type status;

   tdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tdpt_datapath u_datapath (
      .clock        (clock),
      .req_value    (req_value),
      .cmd          (cmd),
      .status       (status),
      .rsp_is_prime (rsp_is_prime)
   );

endmodule

FILE: sv/tdpt_checker.sv
// ----------------------------------------------------------------------------
// tdpt_checker
// Port level checks on the prime test, bound to the top level.
// ----------------------------------------------------------------------------
module tdpt_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic signed [tdpt_pkg::VALUE_WIDTH-1:0] req_value,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic                                   rsp_is_prime
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready ##1 !req_ready)
      else $error("item accepted while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_is_prime))
      else $error("stalled result changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> req_valid && $stable(req_value))
      else $error("stalled request changed");

endmodule

bind trial_division_prime_test tdpt_checker u_checker (.*);

FILE: sim/trial_division_prime_test_tb.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_tb
// Self-checking bench for the trial division primality tester. Each accepted
// value is run through a local trial-division predictor. The expected verdict
// is queued and compared in order with every accepted result. Coverage: a
// directed sweep of edge values, random values with gaps and stalls on, then
// off, a long output hold-off that backs up the input, and a full drain pause.
// ----------------------------------------------------------------------------
module trial_division_prime_test_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tdpt_pkg::*;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct {
      value_type value;
      logic      prime;
   } verdict_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   value_type req_value;
   logic      rsp_valid;
   logic      rsp_ready;
   logic      rsp_is_prime;

   verdict_type expected_verdicts[$];
   int          error_count = 0;
   bit          gaps_on     = 1'b1;
   bit          stalls_on   = 1'b1;
   int          hold_cycles = 0;

   trial_division_prime_test uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_prime (rsp_is_prime)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("trial_division_prime_test verification failed");
      $finish;
   end

   function automatic logic prime_verdict(input value_type v);
      longint unsigned n;
      longint unsigned d;
      if (v < 2) return 1'b0;
      n = longint'(v);
      for (d = 2; d <= n / d; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic send_value(input value_type v);
      int gap;
      verdict_type entry;
      gap = gaps_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      entry.value = v;
      entry.prime = prime_verdict(v);
      expected_verdicts.push_back(entry);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_verdicts.size() != 0);
   endtask

   function automatic value_type random_value();
      int unsigned pick;
      int unsigned f;
      value_type   v;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         v = $urandom_range(0, 4000);
      end else if (pick < 75) begin
         v = $urandom();
         v[VALUE_WIDTH-1] = 1'b1;
      end else if (pick < 90) begin
         // large composite with a small factor keeps the search short
         f = $urandom_range(2, 50);
         v = f * $urandom_range(2, 32'h7FFF_FFFF / f);
      end else begin
         v = $urandom_range(0, 200000);
      end
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type entry;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            if (error_count < 10)
               $display("unexpected result: is_prime=%0b", rsp_is_prime);
            error_count++;
         end else begin
            entry = expected_verdicts.pop_front();
            if (rsp_is_prime !== entry.prime) begin
               if (error_count < 10)
                  $display("mismatch: value=%0d expected is_prime=%0b actual=%0b",
                           entry.value, entry.prime, rsp_is_prime);
               error_count++;
            end
         end
      end
   end

   initial begin : result_side
      int wait_cycles;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = stalls_on ? $urandom_range(0, 16) : 0;
         wait_cycles += hold_cycles;
         hold_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic test_directed_values();
      value_type edge_values[$];
      edge_values = '{32'sh8000_0000, -1, -2, 0, 1, 2, 3, 4, 5, 9, 25, 49, 97, 121,
                      169, 961, 7919, 65521, 65535, 1073741824, 32'sh5555_5555,
                      32'sh7FFF_FFFE, 32'sh7FFF_FFFF};
      foreach (edge_values[i]) send_value(edge_values[i]);
      wait_drained();
   endtask

   task automatic test_random_values();
      repeat (35) send_value(random_value());
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      repeat (20) send_value(random_value());
      wait_drained();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   task automatic test_output_backpressure();
      gaps_on     = 1'b0;
      hold_cycles = 2000;
      repeat (10) send_value($urandom_range(0, 300));
      wait_drained();
      gaps_on = 1'b1;
   endtask

   task automatic test_drain_pause();
      repeat (8) send_value(random_value());
      wait_drained();
      repeat (8) send_value(random_value());
      wait_drained();
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_values();
      test_random_values();
      test_output_backpressure();
      test_drain_pause();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("trial_division_prime_test verification clean");
      end else begin
         $display("trial_division_prime_test verification failed");
      end
      $finish;
   end

endmodule
